// ----- rtl/twrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// twrtc_pkg
// Shared types and constants of the three-wire rtc serial master.
// ----------------------------------------------------------------------------
package twrtc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } twrtc_req_e;

  localparam int unsigned PhaseW = 5;

  localparam logic [7:0]        CMD_MARK   = 8'h80;
  localparam logic [7:0]        READ_FLAG  = 8'h01;
  localparam logic [PhaseW-1:0] PHASE_LAST = 5'd31;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] reg_addr;
    logic [7:0] write_byte;
    logic       data_in;
  } twrtc_req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } twrtc_res_t;

endpackage

// ----- rtl/twrtc_if.sv -----
// ----------------------------------------------------------------------------
// twrtc_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface twrtc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] reg_addr;
  logic [7:0] write_byte;
  logic       data_in;

  modport source (output valid, req_type, reg_addr, write_byte, data_in, input ready);
  modport sink   (input valid, req_type, reg_addr, write_byte, data_in, output ready);
endinterface

interface twrtc_res_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       data_out;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, chip_enable, serial_clock, data_out, data_drive,
                  busy_res, done_res, read_byte, rejected, input ready);
  modport sink   (input valid, chip_enable, serial_clock, data_out, data_drive,
                  busy_res, done_res, read_byte, rejected, output ready);
endinterface

// ----- rtl/twrtc_core.sv -----
// ----------------------------------------------------------------------------
// twrtc_core
// Transaction state and one half-clock step of the serial sequencer.
// ----------------------------------------------------------------------------
module twrtc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  twrtc_pkg::twrtc_req_t item_i,
  output twrtc_pkg::twrtc_res_t res_o
);
  import twrtc_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [15:0]       out_shift_q, out_shift_d;
  logic [7:0]        in_shift_q, in_shift_d;
  logic              is_read_q, is_read_d;
  logic              active_q, active_d;

  logic       start;
  logic [7:0] cmd;
  logic       done;
  logic       rej;
  logic [7:0] rb;
  logic [3:0] bit_idx;

  assign start = (item_i.req_type == REQ_WRITE) || (item_i.req_type == REQ_READ);
  assign cmd   = CMD_MARK | {1'b0, item_i.reg_addr, 1'b0};

  always_comb begin
    phase_d     = phase_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    is_read_d   = is_read_q;
    active_d    = active_q;
    done        = 1'b0;
    rej         = 1'b0;
    rb          = 8'h00;
    if (start && !active_q) begin
      if (item_i.req_type == REQ_READ) begin
        is_read_d   = 1'b1;
        out_shift_d = {8'h00, cmd | READ_FLAG};
      end else begin
        is_read_d   = 1'b0;
        out_shift_d = {item_i.write_byte, cmd};
      end
      in_shift_d = 8'h00;
      phase_d    = '0;
      active_d   = 1'b1;
    end else if (active_q) begin
      rej = start;
      if (phase_q == PHASE_LAST) begin
        active_d = 1'b0;
        done     = 1'b1;
        rb       = is_read_q ? in_shift_q : 8'h00;
        phase_d  = '0;
      end else begin
        // sample on the clock-low half of each data bit
        if (is_read_q && phase_q[PhaseW-1] && !phase_q[0]) begin
          in_shift_d = {item_i.data_in, in_shift_q[7:1]};
        end
        phase_d = phase_q + 1'b1;
      end
    end
  end

  // pin levels after the step
  assign bit_idx = phase_d[PhaseW-1:1];

  always_comb begin
    res_o              = '0;
    res_o.data_drive   = 1'b1;
    res_o.busy_res     = active_d;
    res_o.done_res     = done;
    res_o.read_byte    = rb;
    res_o.rejected     = rej;
    if (active_d) begin
      res_o.chip_enable  = 1'b1;
      res_o.serial_clock = phase_d[0];
      if (is_read_d && bit_idx[3]) begin
        res_o.data_drive = 1'b0;
      end else begin
        res_o.data_out = out_shift_d[bit_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      is_read_q   <= 1'b0;
      active_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      out_shift_q <= out_shift_d;
      in_shift_q  <= in_shift_d;
      is_read_q   <= is_read_d;
      active_q    <= active_d;
    end
  end

  a_last_phase_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && active_q && (phase_q == PHASE_LAST) |=> !active_q)
    else $error("transaction did not end after the last phase");

  a_phase_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && active_q && (phase_q != PHASE_LAST)
    |=> active_q && (phase_q == $past(phase_q) + 1'b1))
    else $error("phase did not advance on a step");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(active_q) && $stable(in_shift_q))
    else $error("state changed without a step");

  a_released_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.data_drive |-> res_o.chip_enable && !res_o.data_out && is_read_d)
    else $error("data line released outside a read");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res && active_q)
    else $error("done flagged while still busy");

endmodule

// ----- rtl/three_wire_rtc_serial_master_top.sv -----
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_top
// Three-wire real-time-clock serial master, one request per half clock.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per half serial clock: a tick (advance the
//   running transfer) or a start of a write or read. Every accepted request
//   gives exactly one result on res_o with the pin levels after that step
//   (chip enable, serial clock, data out and drive enable), busy and done
//   flags, the read byte (valid with done) and a flag for a start that was
//   ignored because a transfer was running.
//   A request is registered in the request register, then stepped through the
//   sequencer into the result register. One request per cycle is sustained
//   while the result sink accepts, as each request performs a single step of
//   the sequencer state.
//   A transfer takes 33 requests: the start plus 32 ticks.
//   Reset empties both registers and leaves the sequencer idle.
//   When the result sink stalls, the pending result holds and the request
//   register fills; req_i.ready drops once both are occupied.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_top (
  input  logic clk_i,
  input  logic rst_ni,
  twrtc_req_if.sink   req_i,
  twrtc_res_if.source res_o
);
  import twrtc_pkg::*;

  logic       s1_valid_q;
  twrtc_req_t s1_q;
  logic       out_valid_q;
  twrtc_res_t out_q;
  twrtc_res_t core_res;
  logic       advance;
  logic       step;

  assign advance     = !out_valid_q || res_o.ready;
  assign step        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= '{req_type:   req_i.req_type,
                reg_addr:   req_i.reg_addr,
                write_byte: req_i.write_byte,
                data_in:    req_i.data_in};
    end
  end

  twrtc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.chip_enable  = out_q.chip_enable;
  assign res_o.serial_clock = out_q.serial_clock;
  assign res_o.data_out     = out_q.data_out;
  assign res_o.data_drive   = out_q.data_drive;
  assign res_o.busy_res     = out_q.busy_res;
  assign res_o.done_res     = out_q.done_res;
  assign res_o.read_byte    = out_q.read_byte;
  assign res_o.rejected     = out_q.rejected;

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped request produced no result");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result was lost or changed");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !res_o.ready |-> !req_i.ready)
    else $error("request taken with both stages full");

endmodule
